FILE: hdl/goertzel_tone_detector_macros.svh
// ----------------------------------------------------------------------------
// Goertzel tone detector assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GOERTZEL_TONE_DETECTOR_MACROS_SVH
`define GOERTZEL_TONE_DETECTOR_MACROS_SVH

// same-cycle implication
`define GTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gtd_pkg.sv
// ----------------------------------------------------------------------------
// Goertzel tone detector package
// Command types and the micro-op sequence shared by controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtd_pkg;

  localparam int STEP_W = 5;

  // step that writes q0; result sequence follows when the block ends
  localparam logic [STEP_W-1:0] STEP_Q         = 5'd3;
  localparam logic [STEP_W-1:0] STEP_RES_FIRST = 5'd4;
  localparam logic [STEP_W-1:0] STEP_LAST      = 5'd25;

  typedef enum logic [3:0] {
    SRC_C, SRC_COS, SRC_SIN,
    SRC_Q1L, SRC_Q1H, SRC_Q2L, SRC_Q2H,
    SRC_P0, SRC_P1, SRC_P2
  } src_t;

  typedef enum logic [1:0] {SH_0, SH_24, SH_48, SH_72} shift_t;

  typedef enum logic [2:0] {
    ST_NONE, ST_Q, ST_P, ST_RE, ST_IM, ST_T, ST_PWR
  } store_t;

  typedef struct packed {
    logic   mul;
    src_t   a;
    src_t   b;
    shift_t sh;
    logic   clr;
    store_t st;
  } uop_t;

  typedef struct packed {
    logic   load;
    logic   mul;
    src_t   a_sel;
    src_t   b_sel;
    shift_t sh;
    logic   clr;
    store_t st;
    logic   publish;
  } dp_cmd_t;

  function automatic uop_t uop_rom(input logic [STEP_W-1:0] step);
    uop_t u;
    case (step)
      // recurrence: c*q1
      5'd0:  u = '{1'b1, SRC_C,   SRC_Q1L, SH_0,  1'b1, ST_NONE};
      5'd1:  u = '{1'b1, SRC_C,   SRC_Q1H, SH_24, 1'b0, ST_NONE};
      5'd3:  u = '{1'b0, SRC_C,   SRC_C,   SH_0,  1'b0, ST_Q};
      // results: c*q1, q2*cos, q2*sin, (c*q1)*q2, q1^2 + q2^2
      5'd4:  u = '{1'b1, SRC_C,   SRC_Q1L, SH_0,  1'b1, ST_NONE};
      5'd5:  u = '{1'b1, SRC_C,   SRC_Q1H, SH_24, 1'b0, ST_NONE};
      5'd6:  u = '{1'b1, SRC_COS, SRC_Q2L, SH_0,  1'b1, ST_NONE};
      5'd7:  u = '{1'b1, SRC_COS, SRC_Q2H, SH_24, 1'b0, ST_P};
      5'd8:  u = '{1'b1, SRC_SIN, SRC_Q2L, SH_0,  1'b1, ST_NONE};
      5'd9:  u = '{1'b1, SRC_SIN, SRC_Q2H, SH_24, 1'b0, ST_RE};
      5'd10: u = '{1'b1, SRC_P0,  SRC_Q2L, SH_0,  1'b1, ST_NONE};
      5'd11: u = '{1'b1, SRC_P0,  SRC_Q2H, SH_24, 1'b0, ST_IM};
      5'd12: u = '{1'b1, SRC_P1,  SRC_Q2L, SH_24, 1'b0, ST_NONE};
      5'd13: u = '{1'b1, SRC_P1,  SRC_Q2H, SH_48, 1'b0, ST_NONE};
      5'd14: u = '{1'b1, SRC_P2,  SRC_Q2L, SH_48, 1'b0, ST_NONE};
      5'd15: u = '{1'b1, SRC_P2,  SRC_Q2H, SH_72, 1'b0, ST_NONE};
      5'd16: u = '{1'b1, SRC_Q1L, SRC_Q1L, SH_0,  1'b1, ST_NONE};
      5'd17: u = '{1'b1, SRC_Q1L, SRC_Q1H, SH_24, 1'b0, ST_T};
      5'd18: u = '{1'b1, SRC_Q1H, SRC_Q1L, SH_24, 1'b0, ST_NONE};
      5'd19: u = '{1'b1, SRC_Q1H, SRC_Q1H, SH_48, 1'b0, ST_NONE};
      5'd20: u = '{1'b1, SRC_Q2L, SRC_Q2L, SH_0,  1'b0, ST_NONE};
      5'd21: u = '{1'b1, SRC_Q2L, SRC_Q2H, SH_24, 1'b0, ST_NONE};
      5'd22: u = '{1'b1, SRC_Q2H, SRC_Q2L, SH_24, 1'b0, ST_NONE};
      5'd23: u = '{1'b1, SRC_Q2H, SRC_Q2H, SH_48, 1'b0, ST_NONE};
      5'd25: u = '{1'b0, SRC_C,   SRC_C,   SH_0,  1'b0, ST_PWR};
      default: u = '{1'b0, SRC_C, SRC_C, SH_0, 1'b0, ST_NONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gtd_datapath.sv
// ----------------------------------------------------------------------------
// Goertzel datapath
// Shared 25x25 multiplier, 112-bit shift-accumulator, delay line and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtd_datapath import gtd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [7:0]         in_sample,
  input  logic signed [16:0] recur_coeff,
  input  logic signed [15:0] bin_cosine,
  input  logic signed [15:0] bin_sine,
  output logic [62:0]        out_power,
  output logic signed [47:0] out_bin_real,
  output logic signed [47:0] out_bin_imag
);

  function automatic logic signed [24:0] pick(
    input src_t               s,
    input logic signed [47:0] q1,
    input logic signed [47:0] q2,
    input logic signed [71:0] p,
    input logic signed [16:0] c,
    input logic signed [15:0] cs,
    input logic signed [15:0] sn
  );
    logic signed [24:0] v;
    case (s)
      SRC_C:   v = {{8{c[16]}}, c};
      SRC_COS: v = {{9{cs[15]}}, cs};
      SRC_SIN: v = {{9{sn[15]}}, sn};
      SRC_Q1L: v = {1'b0, q1[23:0]};
      SRC_Q1H: v = {q1[47], q1[47:24]};
      SRC_Q2L: v = {1'b0, q2[23:0]};
      SRC_Q2H: v = {q2[47], q2[47:24]};
      SRC_P0:  v = {1'b0, p[23:0]};
      SRC_P1:  v = {1'b0, p[47:24]};
      SRC_P2:  v = {p[71], p[71:48]};
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [47:0] sat48(input logic [50:0] v);
    logic signed [47:0] r;
    if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111) begin
      r = v[47:0];
    end else if (v[50]) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  logic signed [47:0]  q1_r, q2_r;
  logic [7:0]          sample_r;
  logic signed [49:0]  prod_r;
  logic                acc_en_r, clr_d_r;
  shift_t              sh_d_r;
  logic [111:0]        acc_r, acc_nxt;
  logic signed [71:0]  p_r;
  logic signed [96:0]  t_r;
  logic signed [47:0]  re_stg_r, im_stg_r;
  logic [62:0]         pwr_stg_r;
  logic [62:0]         power_r;
  logic signed [47:0]  real_r, imag_r;

  logic signed [24:0]  a_op, b_op;
  logic signed [49:0]  prod_nxt;
  logic [111:0]        pp_ext, pp_sh;
  logic [50:0]         q0_w, re_w;
  logic [111:0]        diff_w;
  logic [96:0]         shd_w;
  logic [62:0]         pwr_nxt;

  assign a_op     = pick(cmd.a_sel, q1_r, q2_r, p_r, recur_coeff, bin_cosine, bin_sine);
  assign b_op     = pick(cmd.b_sel, q1_r, q2_r, p_r, recur_coeff, bin_cosine, bin_sine);
  assign prod_nxt = a_op * b_op;

  always_comb begin
    pp_ext = {{62{prod_r[49]}}, prod_r};
    case (sh_d_r)
      SH_0:    pp_sh = pp_ext;
      SH_24:   pp_sh = pp_ext << 24;
      SH_48:   pp_sh = pp_ext << 48;
      SH_72:   pp_sh = pp_ext << 72;
      default: pp_sh = pp_ext;
    endcase
    acc_nxt = (clr_d_r ? 112'd0 : acc_r) + pp_sh;
  end

  // q0 = floor(c*q1 / 2^15) - q2 + sample * 2^15
  assign q0_w = {acc_r[64], acc_r[64:15]} - {{3{q2_r[47]}}, q2_r}
              + {28'b0, sample_r, 15'b0};

  assign re_w = {{3{q1_r[47]}}, q1_r} - {{2{acc_r[63]}}, acc_r[63:15]};

  assign diff_w = acc_r - {{15{t_r[96]}}, t_r};
  assign shd_w  = diff_w[111:15];

  always_comb begin
    if (shd_w[96]) begin
      pwr_nxt = '0;
    end else if (|shd_w[95:63]) begin
      pwr_nxt = '1;
    end else begin
      pwr_nxt = shd_w[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r     <= '0;
      q2_r     <= '0;
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.mul;
      case (cmd.st)
        ST_Q: begin
          q2_r <= q1_r;
          q1_r <= sat48(q0_w);
        end
        ST_PWR: begin
          q1_r <= '0;
          q2_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.mul) begin
      prod_r  <= prod_nxt;
      clr_d_r <= cmd.clr;
      sh_d_r  <= cmd.sh;
    end
    if (acc_en_r) begin
      acc_r <= acc_nxt;
    end
    case (cmd.st)
      ST_P:    p_r       <= acc_r[71:0];
      ST_RE:   re_stg_r  <= sat48(re_w);
      ST_IM:   im_stg_r  <= acc_r[62:15];
      ST_T:    t_r       <= acc_r[111:15];
      ST_PWR:  pwr_stg_r <= pwr_nxt;
      default: begin
      end
    endcase
    if (cmd.publish) begin
      power_r <= pwr_stg_r;
      real_r  <= re_stg_r;
      imag_r  <= im_stg_r;
    end
  end

  assign out_power    = power_r;
  assign out_bin_real = real_r;
  assign out_bin_imag = imag_r;

endmodule

`default_nettype wire

FILE: hdl/gtd_controller.sv
// ----------------------------------------------------------------------------
// Goertzel controller
// Handshakes, block counter and micro-op sequencing of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "goertzel_tone_detector_macros.svh"

module gtd_controller import gtd_pkg::*; #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] block_size,
  output dp_cmd_t     cmd
);

  typedef enum logic [1:0] {IDLE, RUN, PUBLISH} state_t;

  localparam int          CNT_W   = $clog2(MAX_BLOCK);
  localparam logic [16:0] MAX_LEN = 17'(MAX_BLOCK);

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  seen_r;
  logic              out_valid_r;

  logic [16:0] blk_w, len_w, seen_inc;
  logic        last, accept, pub_ok;
  uop_t        uop;

  assign blk_w    = {6'b0, block_size};
  assign len_w    = (blk_w == 17'd0) ? 17'd1 : ((blk_w > MAX_LEN) ? MAX_LEN : blk_w);
  assign seen_inc = 17'(seen_r) + 17'd1;
  assign last     = (seen_inc >= len_w);

  assign uop      = uop_rom(step_r);
  assign in_ready = (state_r == IDLE) || (state_r == RUN && step_r == STEP_Q && !last);
  assign accept   = in_valid && in_ready;
  assign pub_ok   = !out_valid_r || out_ready;

  always_comb begin
    cmd.load    = accept;
    cmd.mul     = (state_r == RUN) && uop.mul;
    cmd.a_sel   = uop.a;
    cmd.b_sel   = uop.b;
    cmd.sh      = uop.sh;
    cmd.clr     = uop.clr;
    cmd.st      = (state_r == RUN) ? uop.st : ST_NONE;
    cmd.publish = (state_r == PUBLISH) && pub_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      step_r      <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (accept) begin
            state_r <= RUN;
            step_r  <= '0;
          end
        end
        RUN: begin
          if (step_r == STEP_Q) begin
            if (last) begin
              seen_r <= '0;
              step_r <= STEP_RES_FIRST;
            end else begin
              seen_r <= seen_inc[CNT_W-1:0];
              if (accept) begin
                step_r <= '0;
              end else begin
                state_r <= IDLE;
              end
            end
          end else if (step_r == STEP_LAST) begin
            state_r <= PUBLISH;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        PUBLISH: begin
          if (pub_ok) begin
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  `GTD_ASSERT_IMPL(a_publish_free, cmd.publish, !out_valid_r || out_ready, "publish over held result")
  `GTD_ASSERT_NEXT(a_accept_starts, accept, state_r == RUN && step_r == '0, "item did not start")
  `GTD_ASSERT_IMPL(a_valid_from_pub, $rose(out_valid_r), $past(cmd.publish), "result without publish")
  `GTD_ASSERT_IMPL(a_block_cleared, state_r == PUBLISH, seen_r == '0, "counter not cleared at block end")

endmodule

`default_nettype wire

FILE: hdl/goertzel_tone_detector.sv
// ----------------------------------------------------------------------------
// Goertzel tone detector
// Single-bin Goertzel over unsigned 8-bit samples, Q.15 fixed point.
// Input channel in_valid/in_ready carries one sample per item. Output channel
// out_valid/out_ready carries power, bin_real and bin_imag once per block of
// block_size samples (0 acts as 1, above MAX_BLOCK acts as MAX_BLOCK).
// Configuration channel cfg_valid/cfg_ready writes cfg_data to register
// cfg_index: 0 recur_coeff, 1 bin_cosine, 2 bin_sine, 3 block_size; write it
// only while the block is idle.
// Within a block a new sample is taken only once the last one's recurrence
// writes q0, after two passes of the single 25x25 multiplier plus its product
// and accumulator registers. A block-ending sample then runs the result
// sequence (the result terms run through the same multiplier); once the
// output is free, the result goes into the output register as out_valid rises.
// Reset clears the delay line, sample counter and output valid, and loads
// the registers with 0, 32767, 0 and 205.
// A stalled receiver holds the result; the next block runs through its last
// sample and result sequence, then waits until the held result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module goertzel_tone_detector import gtd_pkg::*; #(
  parameter int MAX_BLOCK = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [62:0]        out_power,
  output logic signed [47:0] out_bin_real,
  output logic signed [47:0] out_bin_imag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam logic [1:0] REG_RECUR_COEFF = 2'd0;
  localparam logic [1:0] REG_BIN_COSINE  = 2'd1;
  localparam logic [1:0] REG_BIN_SINE    = 2'd2;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd3;

  logic signed [16:0] recur_coeff_r;
  logic signed [15:0] bin_cosine_r;
  logic signed [15:0] bin_sine_r;
  logic [10:0]        block_size_r;
  dp_cmd_t            cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recur_coeff_r <= 17'sd0;
      bin_cosine_r  <= 16'sd32767;
      bin_sine_r    <= 16'sd0;
      block_size_r  <= 11'd205;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECUR_COEFF: recur_coeff_r <= cfg_data;
        REG_BIN_COSINE:  bin_cosine_r  <= cfg_data[15:0];
        REG_BIN_SINE:    bin_sine_r    <= cfg_data[15:0];
        REG_BLOCK_SIZE:  block_size_r  <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  gtd_controller #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .block_size (block_size_r),
    .cmd        (cmd)
  );

  gtd_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_sample    (in_sample),
    .recur_coeff  (recur_coeff_r),
    .bin_cosine   (bin_cosine_r),
    .bin_sine     (bin_sine_r),
    .out_power    (out_power),
    .out_bin_real (out_bin_real),
    .out_bin_imag (out_bin_imag)
  );

endmodule

`default_nettype wire
